/* hdl/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg
// Types and constants shared by the Gregorian date advance core.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int RES_W   = 9;

    localparam logic [YEAR_W-1:0]  YEAR_CYCLE = 14'd400;
    localparam logic [RES_W-1:0]   RES_LAST   = 9'd399;
    localparam logic [RES_W-1:0]   RES_C1     = 9'd100;
    localparam logic [RES_W-1:0]   RES_C2     = 9'd200;
    localparam logic [RES_W-1:0]   RES_C3     = 9'd300;

    // year / 400 == (year * RECIP_400) >> RECIP_SHIFT for every 14-bit year
    localparam int                 RECIP_W     = 13;
    localparam int                 RECIP_SHIFT = 21;
    localparam int                 QUOT_W      = 6;
    localparam int                 PROD_W      = YEAR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_400   = 13'd5243;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_28    = 5'd28;
    localparam logic [DAY_W-1:0]   DAY_29    = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_30    = 5'd30;
    localparam logic [DAY_W-1:0]   DAY_31    = 5'd31;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [COUNT_W-1:0] day_count;
    } in_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } out_item_t;

    // item plus year mod 400, which drives the leap test while stepping
    typedef struct packed {
        in_item_t          item;
        logic [RES_W-1:0]  res400;
    } work_t;

endpackage

/* hdl/gda_front.sv */
// ----------------------------------------------------------------------------
// gda_front
// Accepts items and reduces the start year mod 400 by reciprocal multiply.
// ----------------------------------------------------------------------------
module gda_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gda_pkg::in_item_t  s_data,
    output logic               w_valid,
    input  logic               w_ready,
    output gda_pkg::work_t     w_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_QUOT, ST_REM, ST_PUSH} state_t;

    state_t                        state_reg, state_next;
    gda_pkg::in_item_t             item_reg, item_next;
    logic [gda_pkg::QUOT_W-1:0]    quot_reg, quot_next;
    logic [gda_pkg::RES_W-1:0]     rem_reg, rem_next;
    logic [gda_pkg::PROD_W-1:0]    prod;
    logic [gda_pkg::YEAR_W-1:0]    quot_ext;
    logic [gda_pkg::YEAR_W-1:0]    rem_full;

    assign prod     = {{gda_pkg::RECIP_W{1'b0}}, item_reg.start_year}
                    * {{gda_pkg::YEAR_W{1'b0}}, gda_pkg::RECIP_400};
    assign quot_ext = {{(gda_pkg::YEAR_W - gda_pkg::QUOT_W){1'b0}}, quot_reg};
    assign rem_full = item_reg.start_year - (quot_ext * gda_pkg::YEAR_CYCLE);

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT: begin
                quot_next  = prod[gda_pkg::RECIP_SHIFT +: gda_pkg::QUOT_W];
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = rem_full[gda_pkg::RES_W-1:0];
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (w_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        item_reg <= item_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign w_valid       = (state_reg == ST_PUSH);
    assign w_data.item   = item_reg;
    assign w_data.res400 = rem_reg;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |-> (rem_reg <= gda_pkg::RES_LAST))
        else $error("front remainder not reduced");
    a_quot_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM) |-> (rem_full < gda_pkg::YEAR_CYCLE))
        else $error("front quotient off by one");
    a_calc_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QUOT) |=> (state_reg == ST_REM))
        else $error("front left reduction early");
    a_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && !w_ready) |=> (state_reg == ST_PUSH && $stable(rem_reg)))
        else $error("front dropped pending item");
`endif

endmodule

/* hdl/gda_queue.sv */
// ----------------------------------------------------------------------------
// gda_queue
// Short register FIFO between front and back.
// ----------------------------------------------------------------------------
module gda_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             w_valid,
    output logic             w_ready,
    input  gda_pkg::work_t   w_data,
    output logic             r_valid,
    input  logic             r_ready,
    output gda_pkg::work_t   r_data
);

    localparam int PTR_W = (gda_pkg::QUEUE_DEPTH > 1) ? $clog2(gda_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gda_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(gda_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(gda_pkg::QUEUE_DEPTH - 1);

    gda_pkg::work_t    mem [gda_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push, pop;

    assign w_ready = (cnt_reg != FULL_CNT);
    assign r_valid = (cnt_reg != '0);
    assign r_data  = mem[rptr_reg];
    assign push    = w_valid && w_ready;
    assign pop     = r_valid && r_ready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            mem[wptr_reg] <= w_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers out of step");
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue push not counted");
`endif

endmodule

/* hdl/gda_back.sv */
// ----------------------------------------------------------------------------
// gda_back
// Steps the date one day per cycle and holds the result for the output.
// ----------------------------------------------------------------------------
module gda_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               r_valid,
    output logic               r_ready,
    input  gda_pkg::work_t     r_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gda_pkg::out_item_t m_data
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                          state_reg, state_next;
    logic [gda_pkg::YEAR_W-1:0]      year_reg, year_next;
    logic [gda_pkg::MONTH_W-1:0]     month_reg, month_next;
    logic [gda_pkg::DAY_W-1:0]       day_reg, day_next;
    logic [gda_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [gda_pkg::RES_W-1:0]       res_reg, res_next;
    logic                            mvalid_reg, mvalid_next;
    gda_pkg::out_item_t              mdata_reg, mdata_next;

    logic                            leap;
    logic                            feb;
    logic                            short_month;
    logic                            roll;
    logic [gda_pkg::YEAR_W-1:0]      step_year;
    logic [gda_pkg::MONTH_W-1:0]     step_month;
    logic [gda_pkg::DAY_W-1:0]       step_day;
    logic [gda_pkg::RES_W-1:0]       step_res;

    assign leap = (res_reg[1:0] == 2'd0) && (res_reg != gda_pkg::RES_C1)
               && (res_reg != gda_pkg::RES_C2) && (res_reg != gda_pkg::RES_C3);
    assign feb  = (month_reg == gda_pkg::MONTH_FEB);
    assign short_month = (month_reg == gda_pkg::MONTH_APR) || (month_reg == gda_pkg::MONTH_JUN)
                      || (month_reg == gda_pkg::MONTH_SEP) || (month_reg == gda_pkg::MONTH_NOV);

    always_comb begin
        roll     = 1'b0;
        step_day = day_reg + 1'b1;
        if (feb && day_reg == gda_pkg::DAY_28) begin
            roll = !leap;
        end else if (feb && day_reg == gda_pkg::DAY_29) begin
            roll     = leap;
            step_day = day_reg;
        end else if (short_month && day_reg == gda_pkg::DAY_30) begin
            roll = 1'b1;
        end else if (day_reg == gda_pkg::DAY_31) begin
            roll = 1'b1;
        end
        step_year  = year_reg;
        step_month = month_reg;
        step_res   = res_reg;
        if (roll) begin
            step_day = gda_pkg::DAY_FIRST;
            if (month_reg == gda_pkg::MONTH_DEC) begin
                step_month = gda_pkg::MONTH_JAN;
                step_year  = year_reg + 1'b1;
                // 14-bit year wraps to 0, which is a multiple of 400
                if (year_reg == '1 || res_reg == gda_pkg::RES_LAST) begin
                    step_res = '0;
                end else begin
                    step_res = res_reg + 1'b1;
                end
            end else begin
                step_month = month_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_ready;
        r_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                r_ready = 1'b1;
                if (r_valid) begin
                    year_next  = r_data.item.start_year;
                    month_next = r_data.item.start_month;
                    day_next   = r_data.item.start_day;
                    cnt_next   = r_data.item.day_count;
                    res_next   = r_data.res400;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg != '0) begin
                    year_next  = step_year;
                    month_next = step_month;
                    day_next   = step_day;
                    res_next   = step_res;
                    cnt_next   = cnt_reg - 1'b1;
                end else if (!mvalid_reg || m_ready) begin
                    mdata_next.end_year  = year_reg;
                    mdata_next.end_month = month_reg;
                    mdata_next.end_day   = day_reg;
                    mvalid_next          = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        mdata_reg <= mdata_next;
    end

    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

`ifndef SYNTHESIS
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg != '0) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("day counter skipped");
    a_res_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (res_reg <= gda_pkg::RES_LAST))
        else $error("year residue out of range");
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mvalid_reg) |-> $past(state_reg == ST_RUN && cnt_reg == '0))
        else $error("result posted before stepping done");
`endif

endmodule

/* hdl/gregorian_date_advance_core.sv */
// ----------------------------------------------------------------------------
// gregorian_date_advance_core
// Advances a Gregorian date by a day count, one day per clock.
// ----------------------------------------------------------------------------
// The front end takes an item and reduces the start year mod 400 in its
// QUOT and REM states (a reciprocal multiply for the quotient, then a
// multiply-subtract), then hands it through a 2-entry queue to the stepper.
// The stepper loads the item, advances one day per cycle until day_count
// days are stepped, then posts the date to the output register once that
// register is free or being read. The front works on the next item while
// the stepper is busy.
module gregorian_date_advance_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gda_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gda_pkg::out_item_t m_data
);

    logic            w_valid, w_ready;
    gda_pkg::work_t  w_data;
    logic            r_valid, r_ready;
    gda_pkg::work_t  r_data;

    gda_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .w_valid (w_valid),
        .w_ready (w_ready),
        .w_data  (w_data)
    );

    gda_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .w_valid (w_valid),
        .w_ready (w_ready),
        .w_data  (w_data),
        .r_valid (r_valid),
        .r_ready (r_ready),
        .r_data  (r_data)
    );

    gda_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .r_valid (r_valid),
        .r_ready (r_ready),
        .r_data  (r_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
